// ----- sv/pba_pkg.sv -----
// Package for the pixel binning average block.
// Holds the sample widths, default sizes, register map and configuration type.
// No dependencies.
package pba_pkg;

	localparam int SAMPLE_BITS     = 32;
	localparam int RESULT_BITS     = 32;
	localparam int MAX_OUT_PIXELS_D = 2048;
	localparam int MAX_LEVEL_D     = 4;

	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	localparam int LEVEL_BITS = 3;
	localparam int OPR_BITS   = 12;

	localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 3'd1;
	localparam logic [OPR_BITS-1:0]   OPR_RESET   = 12'd2048;

	typedef enum logic [1:0] {
		REG_LEVEL      = 2'd0,
		REG_BIN_ROWS   = 2'd1,
		REG_OUT_PIXELS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic                  bin_rows_too;
		logic [OPR_BITS-1:0]   out_pixels_per_row;
	} cfg_t;

endpackage

// ----- sv/pba_if.sv -----
// Stream interfaces for the pixel binning average block: samples in, results out.
// Depends on pba_pkg for the field widths.
interface pba_sample_if;
	import pba_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface pba_result_if;
	import pba_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [RESULT_BITS-1:0] binned_value;
	logic                          row_end;

	modport source (output valid, output binned_value, output row_end, input ready);
	modport sink (input valid, input binned_value, input row_end, output ready);
endinterface

// ----- sv/pba_cfg_regs.sv -----
// APB-style configuration registers of the pixel binning average block.
// Depends on pba_pkg for the register map and the configuration struct.
module pba_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pba_pkg::ADDR_BITS-1:0] paddr,
	input  logic [pba_pkg::DATA_BITS-1:0] pwdata,
	output logic [pba_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	output pba_pkg::cfg_t                 cfg
);
	import pba_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level              <= LEVEL_RESET;
			cfg_q.bin_rows_too       <= 1'b0;
			cfg_q.out_pixels_per_row <= OPR_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LEVEL:      cfg_q.level <= pwdata[LEVEL_BITS-1:0];
				REG_BIN_ROWS:   cfg_q.bin_rows_too <= pwdata[0];
				REG_OUT_PIXELS: cfg_q.out_pixels_per_row <= pwdata[OPR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_LEVEL:      prdata = DATA_BITS'(cfg_q.level);
			REG_BIN_ROWS:   prdata = DATA_BITS'(cfg_q.bin_rows_too);
			REG_OUT_PIXELS: prdata = DATA_BITS'(cfg_q.out_pixels_per_row);
			default:        prdata = '0;
		endcase
	end

endmodule

// ----- sv/pixel_binning_average.sv -----
// Top level of the pixel binning average block: bin counters, line store and output register.
// Depends on pba_pkg, pba_if (stream interfaces) and pba_cfg_regs.
//
//   channel   direction  handshake      payload
//   samples   in         valid/ready    sample
//   results   out        valid/ready    binned_value, row_end
//   APB       in         psel/penable   level, bin_rows_too, out_pixels_per_row
//
// One sample is accepted per cycle unless the finishing stage is held by a stalled result.
// With row binning, a completed bin reads the line store in the accept cycle; its sum is
// finished in the next cycle, then goes to the output register or, mid-bin, to the line store.
// Reset clears the counters and valid flags; the line store is not cleared.
// A stalled result holds the finishing stage, which in turn holds the sample input.
module pixel_binning_average #(
	parameter int MAX_OUT_PIXELS = pba_pkg::MAX_OUT_PIXELS_D,
	parameter int MAX_LEVEL      = pba_pkg::MAX_LEVEL_D
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pba_sample_if.sink                    samples,
	pba_result_if.source                  results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pba_pkg::ADDR_BITS-1:0] paddr,
	input  logic [pba_pkg::DATA_BITS-1:0] pwdata,
	output logic [pba_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);
	import pba_pkg::*;

	localparam int IW  = (MAX_OUT_PIXELS > 1) ? $clog2(MAX_OUT_PIXELS) : 1;
	localparam int OW  = ((IW + 1) > (OPR_BITS + 1)) ? (IW + 1) : (OPR_BITS + 1);
	localparam int CW  = MAX_LEVEL + 1;
	localparam int LVW = (MAX_LEVEL > 0) ? $clog2(MAX_LEVEL + 1) : 1;
	localparam int SHW = LVW + 1;
	localparam int RSW = SAMPLE_BITS + MAX_LEVEL;
	localparam int ASW = SAMPLE_BITS + 2 * MAX_LEVEL;

	cfg_t cfg;

	pba_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [CW-1:0]         pixel_in_bin_q;
	logic [IW-1:0]         out_pixel_index_q;
	logic [CW-1:0]         row_in_bin_q;
	logic signed [RSW-1:0] run_sum_q;

	logic signed [ASW-1:0] line_mem [MAX_OUT_PIXELS];
	logic signed [ASW-1:0] line_rd_q;

	logic                  s1_valid_q;
	logic signed [RSW-1:0] bin_sum_s1;
	logic [IW-1:0]         idx_s1;
	logic                  last_px_s1;
	logic                  first_row_s1;
	logic                  emit_s1;
	logic                  rows_s1;
	logic [LVW-1:0]        lv_s1;

	logic                  out_valid_q;
	logic signed [RESULT_BITS-1:0] binned_value_q;
	logic                  row_end_q;

	logic [LVW-1:0]        lv;
	logic [CW-1:0]         bin;
	logic [OW-1:0]         opr;
	logic [CW-1:0]         pib_inc;
	logic [CW-1:0]         row_inc;
	logic [OW-1:0]         opi_inc;
	logic                  complete;
	logic                  last_px;
	logic                  last_row;
	logic signed [RSW-1:0] sum_in;
	logic                  take;
	logic                  rd_en;

	logic signed [ASW-1:0] acc;
	logic signed [ASW-1:0] shifted;
	logic [SHW-1:0]        shift;
	logic                  wr_en;
	logic                  out_free;
	logic                  s1_adv;

	always_comb begin
		if (int'(cfg.level) > MAX_LEVEL) begin
			lv = LVW'(MAX_LEVEL);
		end else begin
			lv = LVW'(cfg.level);
		end
		bin = CW'(1) << lv;

		if (cfg.out_pixels_per_row == '0) begin
			opr = OW'(1);
		end else if (int'(cfg.out_pixels_per_row) > MAX_OUT_PIXELS) begin
			opr = OW'(MAX_OUT_PIXELS);
		end else begin
			opr = OW'(cfg.out_pixels_per_row);
		end

		pib_inc  = pixel_in_bin_q + CW'(1);
		row_inc  = row_in_bin_q + CW'(1);
		opi_inc  = OW'(out_pixel_index_q) + OW'(1);
		complete = pib_inc >= bin;
		last_px  = opi_inc >= opr;
		last_row = row_inc >= bin;
		sum_in   = run_sum_q + RSW'(samples.sample);
	end

	assign take  = samples.valid && samples.ready;
	assign rd_en = take && complete && cfg.bin_rows_too;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_in_bin_q    <= '0;
			out_pixel_index_q <= '0;
			row_in_bin_q      <= '0;
			run_sum_q         <= '0;
		end else if (take) begin
			if (complete) begin
				run_sum_q      <= '0;
				pixel_in_bin_q <= '0;
				if (last_px) begin
					out_pixel_index_q <= '0;
					if (cfg.bin_rows_too && !last_row) begin
						row_in_bin_q <= row_inc;
					end else begin
						row_in_bin_q <= '0;
					end
				end else begin
					out_pixel_index_q <= opi_inc[IW-1:0];
				end
			end else begin
				run_sum_q      <= sum_in;
				pixel_in_bin_q <= pib_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[idx_s1] <= acc;
		end
		if (rd_en) begin
			line_rd_q <= line_mem[out_pixel_index_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (samples.ready) begin
			s1_valid_q <= take && complete;
		end
	end

	always_ff @(posedge clk) begin
		if (take && complete) begin
			bin_sum_s1   <= sum_in;
			idx_s1       <= out_pixel_index_q;
			last_px_s1   <= last_px;
			first_row_s1 <= row_in_bin_q == '0;
			emit_s1      <= !cfg.bin_rows_too || last_row;
			rows_s1      <= cfg.bin_rows_too;
			lv_s1        <= lv;
		end
	end

	always_comb begin
		if (rows_s1 && !first_row_s1) begin
			acc = ASW'(bin_sum_s1) + line_rd_q;
		end else begin
			acc = ASW'(bin_sum_s1);
		end
		if (rows_s1) begin
			shift = {lv_s1, 1'b0};
		end else begin
			shift = {1'b0, lv_s1};
		end
		shifted = acc >>> shift;
	end

	assign out_free        = !out_valid_q || results.ready;
	assign s1_adv          = s1_valid_q && (!emit_s1 || out_free);
	assign wr_en           = s1_valid_q && !emit_s1;
	assign samples.ready   = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			binned_value_q <= shifted[RESULT_BITS-1:0];
			row_end_q      <= last_px_s1;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.binned_value = binned_value_q;
	assign results.row_end      = row_end_q;

endmodule
